@@ src/ltc_pkg.sv @@
// Package for the lexical token classifier: types, terminal table, character classes.
// Used by lexical_token_classifier_core. No dependencies.
package ltc_pkg;

  localparam int NAME_CHARS     = 16;
  localparam int SYMBOL_ENTRIES = 16;
  localparam int TERM_COUNT     = 28;
  localparam int TERM_MAX       = 6;

  localparam logic [1:0] CLS_TERMINAL = 2'd0;
  localparam logic [1:0] CLS_LITERAL  = 2'd1;
  localparam logic [1:0] CLS_SYMBOL   = 2'd2;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [47:0] TERM_NAME [TERM_COUNT] = '{
    48'("("), 48'(")"), 48'("{"), 48'("}"), 48'("="), 48'(";"), 48'("+"), 48'("-"),
    48'("*"), 48'("/"), 48'("%"), 48'("<"), 48'(">"), 48'("&"), 48'("|"),
    48'("=="), 48'("+="), 48'("-="), 48'("*="), 48'("<="), 48'(">="), 48'("&&"),
    48'("||"), 48'("void"), 48'("int"), 48'("if"), 48'("printf"), 48'("scanf")
  };
  localparam int TERM_LEN [TERM_COUNT] = '{
    1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
    2, 2, 2, 2, 2, 2, 2, 2,
    4, 3, 2, 6, 5
  };

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STRING,
    MODE_OPER
  } scan_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHA,
    ST_PHB,
    ST_EOT,
    ST_CLASS,
    ST_RD,
    ST_CHK,
    ST_INS,
    ST_PUSH,
    ST_FIN
  } ltc_state_e;

  typedef enum logic [1:0] {
    RET_PHB,
    RET_EOT,
    RET_FIN
  } ret_e;

  typedef struct packed {
    logic [1:0] cls;
    logic [4:0] id;
    logic [4:0] len;
    logic       full;
    logic       over;
    logic       last;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return ((c >= 8'h21) && (c <= 8'h2F)) || ((c >= 8'h3A) && (c <= 8'h40)) ||
           ((c >= 8'h5B) && (c <= 8'h60)) || ((c >= 8'h7B) && (c <= 8'h7E));
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h3D) || (c == 8'h2A) ||
           (c == 8'h2F) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h25) ||
           (c == 8'h26) || (c == 8'h7C);
  endfunction

  // tt holds character k at bits [8k+7:8k]; returns one-based terminal index or zero
  function automatic logic [4:0] term_match(input logic [8*TERM_MAX-1:0] tt,
                                            input logic [5:0] cnt);
    logic [4:0] id;
    logic       eq;
    id = '0;
    for (int j = TERM_COUNT - 1; j >= 0; j--) begin
      eq = (cnt == 6'(TERM_LEN[j]));
      for (int k = 0; k < TERM_MAX; k++) begin
        if (k < TERM_LEN[j] && tt[8*k +: 8] != TERM_NAME[j][8*(TERM_LEN[j]-1-k) +: 8]) begin
          eq = 1'b0;
        end
      end
      if (eq) begin
        id = 5'(j + 1);
      end
    end
    return id;
  endfunction

endpackage

@@ src/ltc_symtab.sv @@
// Symbol table storage: name characters and name lengths, synchronous memories.
// One read and one write per cycle each, read data registered. Depends on nothing.
module ltc_symtab #(
  parameter int SymbolEntries = 16,
  parameter int KW            = 4,
  parameter int KCW           = 5,
  parameter int JW            = 4
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [JW-1:0]   rd_slot_i,
  input  logic [KW-1:0]   rd_char_i,
  output logic [7:0]      rd_name_o,
  output logic [KCW-1:0]  rd_len_o,
  input  logic            wr_name_en_i,
  input  logic            wr_len_en_i,
  input  logic [JW-1:0]   wr_slot_i,
  input  logic [KW-1:0]   wr_char_i,
  input  logic [7:0]      wr_name_i,
  input  logic [KCW-1:0]  wr_len_i
);

  localparam int Depth = SymbolEntries * (2 ** KW);

  logic [7:0]     names_q [Depth];
  logic [KCW-1:0] lens_q  [SymbolEntries];

  always_ff @(posedge clk_i) begin
    if (wr_name_en_i) begin
      names_q[{wr_slot_i, wr_char_i}] <= wr_name_i;
    end
    if (wr_len_en_i) begin
      lens_q[wr_slot_i] <= wr_len_i;
    end
    if (rd_en_i) begin
      rd_name_o <= names_q[{rd_slot_i, rd_char_i}];
      rd_len_o  <= lens_q[rd_slot_i];
    end
  end

endmodule

@@ src/lexical_token_classifier_core.sv @@
// Top level of the lexical token classifier: scanner, classifier sequencer, result stage.
// Depends on ltc_pkg and ltc_symtab.
//
// One character beat is taken at a time; the input stalls until every token it causes has
// been classified and handed to the result stage. A finished token first gets the terminal
// and literal check; a symbol then walks the symbol table through the memory read port,
// reading each entry's length and, where the length matches, comparing its characters one
// by one, and a new symbol stores its characters one at a time. Results leave through
// a one-entry holding stage and an output register so the last token of a beat can be
// flagged.
module lexical_token_classifier_core #(
  parameter int NameChars     = ltc_pkg::NAME_CHARS,
  parameter int SymbolEntries = ltc_pkg::SYMBOL_ENTRIES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] token_class_o,
  output logic [4:0] token_id_o,
  output logic [4:0] token_length_o,
  output logic       table_full_o,
  output logic       too_long_o,
  output logic       last_of_run_o
);
  import ltc_pkg::*;

  localparam int KW  = (NameChars > 1) ? $clog2(NameChars) : 1;
  localparam int KCW = $clog2(NameChars + 1);
  localparam int JW  = (SymbolEntries > 1) ? $clog2(SymbolEntries) : 1;
  localparam int JCW = $clog2(SymbolEntries + 1);

  ltc_state_e state_q, state_d;
  ret_e       ret_q, ret_d;
  scan_mode_e mode_q, mode_d;

  logic [7:0]     c_q;
  logic           eot_q;
  logic [7:0]     text_q [NameChars];
  logic [KCW-1:0] cnt_q, cnt_d;
  logic           over_q, over_d;
  logic [JCW-1:0] j_q, j_d, syms_q, syms_d, lits_q, lits_d;
  logic [KCW-1:0] k_q, k_d;
  result_t        res_q, res_d, pend_q, pend_d, out_q, out_d;
  logic           pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic           add_en;

  logic                  c_alnum, c_oper, c_quote, c_single;
  logic [8*TERM_MAX-1:0] tt;
  logic [4:0]            term_id;
  logic                  is_lit;
  logic                  out_free, push_go;
  logic                  chk_miss, chk_hit;

  logic           rd_en, wr_name_en, wr_len_en;
  logic [7:0]     rd_name;
  logic [KCW-1:0] rd_len;

  assign c_alnum  = is_alnum(c_q);
  assign c_oper   = is_oper(c_q);
  assign c_quote  = (c_q == CH_QUOTE);
  assign c_single = is_punct(c_q) && (c_q != CH_COMMA) && !c_quote && !c_oper;

  always_comb begin
    tt = '0;
    for (int i = 0; i < TERM_MAX; i++) begin
      if (i < NameChars) begin
        tt[8*i +: 8] = text_q[i];
      end
    end
  end

  assign term_id  = over_q ? 5'd0 : term_match(tt, 6'(cnt_q));
  assign is_lit   = (cnt_q != '0) && (is_digit(text_q[0]) || text_q[0] == CH_QUOTE);
  assign out_free = !out_v_q || !out_stall_i;
  assign push_go  = !pend_v_q || out_free;
  assign chk_miss = (rd_len != cnt_q) ||
                    ((cnt_q != '0) && (rd_name != text_q[k_q[KW-1:0]]));
  assign chk_hit  = !chk_miss && ((cnt_q == '0) || (k_q == cnt_q - 1'b1));

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PHA;
      end
      ST_PHA: begin
        unique case (mode_q)
          MODE_STRING: begin
            state_d = c_quote ? ST_CLASS : ST_EOT;
            ret_d   = RET_EOT;
          end
          MODE_OPER: begin
            state_d = ST_CLASS;
            ret_d   = c_oper ? RET_EOT : RET_PHB;
          end
          MODE_WORD: begin
            state_d = c_alnum ? ST_EOT : ST_CLASS;
            ret_d   = RET_PHB;
          end
          default: state_d = ST_PHB;
        endcase
      end
      ST_PHB: begin
        state_d = c_single ? ST_CLASS : ST_EOT;
        ret_d   = RET_EOT;
      end
      ST_EOT: begin
        state_d = (eot_q && mode_q != MODE_IDLE) ? ST_CLASS : ST_FIN;
        ret_d   = RET_FIN;
      end
      ST_CLASS: state_d = (term_id != '0 || is_lit) ? ST_PUSH : ST_RD;
      ST_RD:    state_d = (j_q == syms_q) ? ST_INS : ST_CHK;
      ST_CHK:   state_d = chk_hit ? ST_PUSH : ST_RD;
      ST_INS: begin
        if (syms_q == JCW'(SymbolEntries) || k_q == cnt_q) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (push_go) begin
          unique case (ret_q)
            RET_PHB: state_d = ST_PHB;
            RET_EOT: state_d = ST_EOT;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        if (push_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    over_d     = over_q;
    add_en     = 1'b0;
    j_d        = j_q;
    k_d        = k_q;
    syms_d     = syms_q;
    lits_d     = lits_q;
    res_d      = res_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_d      = out_q;
    out_v_d    = out_v_q && out_stall_i;
    rd_en      = 1'b0;
    wr_name_en = 1'b0;
    wr_len_en  = 1'b0;
    unique case (state_q)
      ST_PHA: begin
        unique case (mode_q)
          MODE_STRING: begin
            add_en = 1'b1;
            if (c_quote) mode_d = MODE_IDLE;
          end
          MODE_OPER: begin
            add_en = c_oper;
            mode_d = MODE_IDLE;
          end
          MODE_WORD: begin
            if (c_alnum) begin
              add_en = 1'b1;
            end else begin
              mode_d = MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      ST_PHB: begin
        priority if (c_alnum) begin
          add_en = 1'b1;
          mode_d = MODE_WORD;
        end else if (c_quote) begin
          add_en = 1'b1;
          mode_d = MODE_STRING;
        end else if (c_oper) begin
          add_en = 1'b1;
          mode_d = MODE_OPER;
        end else begin
          add_en = c_single;
        end
      end
      ST_EOT: begin
        if (eot_q) mode_d = MODE_IDLE;
      end
      ST_CLASS: begin
        res_d.len  = 5'(cnt_q);
        res_d.over = over_q;
        res_d.full = 1'b0;
        res_d.last = 1'b0;
        j_d        = '0;
        k_d        = '0;
        priority if (term_id != '0) begin
          res_d.cls = CLS_TERMINAL;
          res_d.id  = term_id;
        end else if (is_lit) begin
          res_d.cls = CLS_LITERAL;
          if (lits_q < JCW'(SymbolEntries)) begin
            lits_d   = lits_q + 1'b1;
            res_d.id = 5'(lits_q + 1'b1);
          end else begin
            res_d.id   = '0;
            res_d.full = 1'b1;
          end
        end else begin
          res_d.cls = CLS_SYMBOL;
        end
      end
      ST_RD: begin
        rd_en = (j_q != syms_q);
      end
      ST_CHK: begin
        if (chk_hit) begin
          res_d.id = 5'(j_q + 1'b1);
        end else if (chk_miss) begin
          j_d = j_q + 1'b1;
          k_d = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_INS: begin
        priority if (syms_q == JCW'(SymbolEntries)) begin
          res_d.id   = '0;
          res_d.full = 1'b1;
        end else if (k_q == cnt_q) begin
          wr_len_en = 1'b1;
          syms_d    = syms_q + 1'b1;
          res_d.id  = 5'(syms_q + 1'b1);
        end else begin
          wr_name_en = 1'b1;
          k_d        = k_q + 1'b1;
        end
      end
      ST_PUSH: begin
        if (push_go) begin
          if (pend_v_q) begin
            out_d   = pend_q;
            out_v_d = 1'b1;
          end
          pend_d   = res_q;
          pend_v_d = 1'b1;
          cnt_d    = '0;
          over_d   = 1'b0;
        end
      end
      ST_FIN: begin
        if (push_go && pend_v_q) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      default: ;
    endcase
    if (add_en) begin
      if (cnt_q < KCW'(NameChars)) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        over_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= RET_FIN;
      mode_q   <= MODE_IDLE;
      cnt_q    <= '0;
      over_q   <= 1'b0;
      syms_q   <= '0;
      lits_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      mode_q   <= mode_d;
      cnt_q    <= cnt_d;
      over_q   <= over_d;
      syms_q   <= syms_d;
      lits_q   <= lits_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      c_q   <= text_byte_i;
      eot_q <= end_of_text_i;
    end
    if (add_en && cnt_q < KCW'(NameChars)) begin
      text_q[cnt_q[KW-1:0]] <= c_q;
    end
    j_q    <= j_d;
    k_q    <= k_d;
    res_q  <= res_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  ltc_symtab #(
    .SymbolEntries(SymbolEntries),
    .KW           (KW),
    .KCW          (KCW),
    .JW           (JW)
  ) u_symtab (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_slot_i   (j_q[JW-1:0]),
    .rd_char_i   (k_q[KW-1:0]),
    .rd_name_o   (rd_name),
    .rd_len_o    (rd_len),
    .wr_name_en_i(wr_name_en),
    .wr_len_en_i (wr_len_en),
    .wr_slot_i   (syms_q[JW-1:0]),
    .wr_char_i   (k_q[KW-1:0]),
    .wr_name_i   (text_q[k_q[KW-1:0]]),
    .wr_len_i    (cnt_q)
  );

  assign out_valid_o    = out_v_q;
  assign token_class_o  = out_q.cls;
  assign token_id_o     = out_q.id;
  assign token_length_o = out_q.len;
  assign table_full_o   = out_q.full;
  assign too_long_o     = out_q.over;
  assign last_of_run_o  = out_q.last;

endmodule
